// ===== sv/arpre_pkg.sv =====
// Shared types and constants of the ARP resolution engine.
package arpre_pkg;

    localparam logic [1:0] OP_SEND = 2'd0;
    localparam logic [1:0] OP_RECV = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    localparam logic [1:0] FT_IPV4 = 2'd0;
    localparam logic [1:0] FT_ARP  = 2'd1;

    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_REQUEST = 3'd1;
    localparam logic [2:0] KIND_REPLY   = 3'd2;
    localparam logic [2:0] KIND_DELIVER = 3'd3;
    localparam logic [2:0] KIND_DROP    = 3'd4;

    localparam logic [1:0] CFG_OWN_MAC  = 2'd0;
    localparam logic [1:0] CFG_OWN_IP   = 2'd1;
    localparam logic [1:0] CFG_LIFETIME = 2'd2;
    localparam logic [1:0] CFG_RETRY    = 2'd3;

    localparam logic [19:0] LIFETIME_RESET = 20'd30000;
    localparam logic [19:0] RETRY_RESET    = 20'd5000;
    localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] hop_addr;
        logic [15:0] datagram_tag;
        logic [47:0] frame_dst_mac;
        logic [1:0]  frame_type;
        logic        payload_ok;
        logic        arp_is_request;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip;
        logic [15:0] elapsed_ms;
    } arpre_in_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [47:0] out_mac;
        logic [31:0] out_ip;
        logic [15:0] out_tag;
        logic        last;
    } arpre_out_t;

    typedef struct packed {
        logic [47:0] own_mac;
        logic [31:0] own_ip;
        logic [19:0] entry_lifetime_ms;
        logic [19:0] retry_interval_ms;
    } arpre_cfg_t;

endpackage

// ===== sv/arpre_obuf.sv =====
// Output register that decouples the engine from the result channel.
module arpre_obuf import arpre_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       in_valid,
    output logic       in_ready,
    input  arpre_out_t in_data,
    output logic       m_valid,
    input  logic       m_ready,
    output arpre_out_t m_data
);

    logic       m_valid_reg;
    arpre_out_t m_data_reg;

    assign in_ready = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_ready) begin
            m_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            m_data_reg <= in_data;
        end
    end

endmodule

// ===== sv/arpre_core.sv =====
// Sequencer that processes each transaction, scanning the mapping, request and waiting memories as its operation needs.
module arpre_core import arpre_pkg::*; #(
    parameter int MAP_ENTRIES  = 16,
    parameter int REQ_ENTRIES  = 8,
    parameter int WAIT_ENTRIES = 16
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  arpre_cfg_t cfg,
    input  logic       s_valid,
    output logic       s_ready,
    input  arpre_in_t  s_data,
    output logic       ob_valid,
    input  logic       ob_ready,
    output arpre_out_t ob_data
);

    localparam int MAW  = (MAP_ENTRIES > 1) ? $clog2(MAP_ENTRIES) : 1;
    localparam int RAW  = (REQ_ENTRIES > 1) ? $clog2(REQ_ENTRIES) : 1;
    localparam int WAW  = (WAIT_ENTRIES > 1) ? $clog2(WAIT_ENTRIES) : 1;
    localparam int MAXN = (MAP_ENTRIES > REQ_ENTRIES) ?
        ((MAP_ENTRIES > WAIT_ENTRIES) ? MAP_ENTRIES : WAIT_ENTRIES) :
        ((REQ_ENTRIES > WAIT_ENTRIES) ? REQ_ENTRIES : WAIT_ENTRIES);
    localparam int CW   = $clog2(MAXN + 1);
    localparam int WCW  = $clog2(WAIT_ENTRIES + 1);

    typedef enum logic [3:0] {
        ST_IDLE, ST_DECODE, ST_MAP_SCAN, ST_LEARN_WR, ST_WAIT_SCAN,
        ST_SEND_WAIT, ST_REQ_SCAN, ST_SEND_REQ, ST_FINISH
    } state_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } map_word_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [31:0] stamp;
    } req_word_t;

    typedef struct packed {
        logic [31:0] ip;
        logic [15:0] tag;
    } wait_word_t;

    state_t                  state_reg;
    arpre_in_t               item_reg;
    logic [31:0]             now_reg;
    logic [CW-1:0]           idx_reg;
    logic [WCW-1:0]          j_reg;
    logic [WCW-1:0]          wait_cnt_reg;
    logic [MAP_ENTRIES-1:0]  map_valid_reg;
    logic [REQ_ENTRIES-1:0]  req_valid_reg;
    logic                    hit_found_reg;
    logic [CW-1:0]           hit_idx_reg;
    logic                    free_found_reg;
    logic [CW-1:0]           free_idx_reg;
    logic [CW-1:0]           old_idx_reg;
    logic [31:0]             old_age_reg;
    logic                    pend_valid_reg;
    arpre_out_t              pend_reg;

    map_word_t  map_mem [MAP_ENTRIES];
    req_word_t  req_mem [REQ_ENTRIES];
    wait_word_t wait_mem [WAIT_ENTRIES];
    map_word_t  map_rd_reg;
    req_word_t  req_rd_reg;
    wait_word_t wait_rd_reg;

    logic           map_we, req_we, wait_we;
    logic [MAW-1:0] map_wa, map_ra;
    logic [RAW-1:0] req_wa, req_ra;
    logic [WAW-1:0] wait_wa, wait_ra;
    map_word_t      map_wd;
    req_word_t      req_wd;
    wait_word_t     wait_wd;

    logic        emit_req, can_emit, step;
    arpre_out_t  emit_res;
    logic [CW-1:0] idx_inc;
    logic        map_last, req_last, wait_done, wait_full;
    logic        map_v, req_v, map_ip_hit, req_ip_hit;
    logic [31:0] map_age, req_age, scan_ip;
    logic        addr_ok, arp_good, dec_scan;
    logic [MAW-1:0] learn_slot;

    assign idx_inc   = idx_reg + 1'b1;
    assign map_last  = idx_reg == CW'(MAP_ENTRIES - 1);
    assign req_last  = idx_reg == CW'(REQ_ENTRIES - 1);
    assign wait_done = idx_reg >= CW'(wait_cnt_reg);
    assign wait_full = wait_cnt_reg == WCW'(WAIT_ENTRIES);
    assign map_v     = map_valid_reg[idx_reg[MAW-1:0]];
    assign req_v     = req_valid_reg[idx_reg[RAW-1:0]];
    assign map_age   = now_reg - map_rd_reg.stamp;
    assign req_age   = now_reg - req_rd_reg.stamp;
    // Sends look up the next hop, receives look up the ARP sender.
    assign scan_ip    = (item_reg.operation == OP_SEND) ? item_reg.hop_addr
                                                        : item_reg.arp_sender_ip;
    assign map_ip_hit = map_v && (map_rd_reg.ip == scan_ip);
    assign req_ip_hit = req_v && (req_rd_reg.ip == scan_ip);
    assign addr_ok    = (item_reg.frame_dst_mac == cfg.own_mac) ||
                        (item_reg.frame_dst_mac == BCAST_MAC);
    assign arp_good   = addr_ok && (item_reg.frame_type == FT_ARP) && item_reg.payload_ok;
    assign dec_scan   = (item_reg.operation == OP_SEND) || (item_reg.operation == OP_TICK) ||
                        ((item_reg.operation == OP_RECV) && arp_good);
    assign learn_slot = hit_found_reg ? hit_idx_reg[MAW-1:0] :
                        free_found_reg ? free_idx_reg[MAW-1:0] : old_idx_reg[MAW-1:0];

    // A result is held back until the next result or the finish, so the final one can carry the last flag.
    assign can_emit = !pend_valid_reg || ob_ready;
    assign step     = !emit_req || can_emit;
    assign s_ready  = state_reg == ST_IDLE;
    assign ob_valid = pend_valid_reg && (emit_req || state_reg == ST_FINISH);

    always_comb begin
        ob_data      = pend_reg;
        ob_data.last = state_reg == ST_FINISH;
    end

    // Read addresses run one entry ahead of the entry being processed.
    always_comb begin
        map_ra  = '0;
        req_ra  = '0;
        wait_ra = '0;
        if (state_reg == ST_MAP_SCAN) begin
            map_ra = step ? idx_inc[MAW-1:0] : idx_reg[MAW-1:0];
        end
        if (state_reg == ST_REQ_SCAN) begin
            req_ra = step ? idx_inc[RAW-1:0] : idx_reg[RAW-1:0];
        end
        if (state_reg == ST_WAIT_SCAN) begin
            wait_ra = (step && !wait_done) ? idx_inc[WAW-1:0] : idx_reg[WAW-1:0];
        end
    end

    always_comb begin
        emit_req = 1'b0;
        emit_res = '0;
        map_we   = 1'b0;
        map_wa   = learn_slot;
        map_wd   = '{ip: item_reg.arp_sender_ip, mac: item_reg.arp_sender_mac, stamp: now_reg};
        req_we   = 1'b0;
        req_wa   = idx_reg[RAW-1:0];
        req_wd   = '{ip: req_rd_reg.ip, stamp: now_reg};
        wait_we  = 1'b0;
        wait_wa  = j_reg[WAW-1:0];
        wait_wd  = wait_rd_reg;
        unique case (state_reg)
            ST_DECODE: begin
                if (item_reg.operation == OP_RECV && addr_ok && item_reg.payload_ok) begin
                    if (item_reg.frame_type == FT_IPV4) begin
                        emit_req      = 1'b1;
                        emit_res.kind = KIND_DELIVER;
                    end else if (item_reg.frame_type == FT_ARP && item_reg.arp_is_request &&
                                 item_reg.arp_target_ip == cfg.own_ip) begin
                        emit_req         = 1'b1;
                        emit_res.kind    = KIND_REPLY;
                        emit_res.out_mac = item_reg.arp_sender_mac;
                        emit_res.out_ip  = item_reg.arp_sender_ip;
                    end
                end
            end
            ST_MAP_SCAN: begin
                if (item_reg.operation == OP_SEND && map_ip_hit) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_FRAME;
                    emit_res.out_mac = map_rd_reg.mac;
                    emit_res.out_tag = item_reg.datagram_tag;
                end
            end
            ST_LEARN_WR: begin
                map_we = 1'b1;
            end
            ST_WAIT_SCAN: begin
                if (!wait_done) begin
                    if (wait_rd_reg.ip == item_reg.arp_sender_ip) begin
                        emit_req         = 1'b1;
                        emit_res.kind    = KIND_FRAME;
                        emit_res.out_mac = item_reg.arp_sender_mac;
                        emit_res.out_tag = wait_rd_reg.tag;
                    end else begin
                        wait_we = 1'b1;
                    end
                end
            end
            ST_SEND_WAIT: begin
                if (wait_full) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_DROP;
                    emit_res.out_tag = item_reg.datagram_tag;
                end else begin
                    wait_we = 1'b1;
                    wait_wa = wait_cnt_reg[WAW-1:0];
                    wait_wd = '{ip: item_reg.hop_addr, tag: item_reg.datagram_tag};
                end
            end
            ST_REQ_SCAN: begin
                if (item_reg.operation == OP_TICK && req_v &&
                    req_age >= 32'(cfg.retry_interval_ms)) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_REQUEST;
                    emit_res.out_mac = BCAST_MAC;
                    emit_res.out_ip  = req_rd_reg.ip;
                    req_we           = can_emit;
                end
            end
            ST_SEND_REQ: begin
                if (!hit_found_reg) begin
                    emit_req         = 1'b1;
                    emit_res.kind    = KIND_REQUEST;
                    emit_res.out_mac = BCAST_MAC;
                    emit_res.out_ip  = item_reg.hop_addr;
                    req_we           = free_found_reg && can_emit;
                    req_wa           = free_idx_reg[RAW-1:0];
                    req_wd           = '{ip: item_reg.hop_addr, stamp: now_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (map_we) begin
            map_mem[map_wa] <= map_wd;
        end
        map_rd_reg <= map_mem[map_ra];
    end

    always_ff @(posedge aclk) begin
        if (req_we) begin
            req_mem[req_wa] <= req_wd;
        end
        req_rd_reg <= req_mem[req_ra];
    end

    always_ff @(posedge aclk) begin
        if (wait_we) begin
            wait_mem[wait_wa] <= wait_wd;
        end
        wait_rd_reg <= wait_mem[wait_ra];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            now_reg        <= '0;
            wait_cnt_reg   <= '0;
            map_valid_reg  <= '0;
            req_valid_reg  <= '0;
            pend_valid_reg <= 1'b0;
            idx_reg        <= '0;
            j_reg          <= '0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        item_reg  <= s_data;
                        state_reg <= ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    idx_reg        <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    if (step) begin
                        if (item_reg.operation == OP_TICK) begin
                            now_reg <= now_reg + 32'(item_reg.elapsed_ms);
                        end
                        state_reg <= dec_scan ? ST_MAP_SCAN : ST_FINISH;
                    end
                end
                ST_MAP_SCAN: begin
                    if (step) begin
                        idx_reg <= map_last ? '0 : idx_inc;
                        if (item_reg.operation == OP_SEND) begin
                            if (map_ip_hit) begin
                                state_reg <= ST_FINISH;
                            end else if (map_last) begin
                                state_reg <= ST_SEND_WAIT;
                            end
                        end else if (item_reg.operation == OP_RECV) begin
                            if (map_ip_hit && !hit_found_reg) begin
                                hit_found_reg <= 1'b1;
                                hit_idx_reg   <= idx_reg;
                            end
                            if (!map_v && !free_found_reg) begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= idx_reg;
                            end
                            // Oldest entry only matters when every entry is valid.
                            if (map_v && (idx_reg == '0 || map_age > old_age_reg)) begin
                                old_idx_reg <= idx_reg;
                                old_age_reg <= map_age;
                            end
                            if (map_last) begin
                                state_reg <= ST_LEARN_WR;
                            end
                        end else begin
                            if (map_v && map_age >= 32'(cfg.entry_lifetime_ms)) begin
                                map_valid_reg[idx_reg[MAW-1:0]] <= 1'b0;
                            end
                            if (map_last) begin
                                state_reg <= ST_REQ_SCAN;
                            end
                        end
                    end
                end
                ST_LEARN_WR: begin
                    map_valid_reg[learn_slot] <= 1'b1;
                    idx_reg        <= '0;
                    j_reg          <= '0;
                    hit_found_reg  <= 1'b0;
                    free_found_reg <= 1'b0;
                    state_reg      <= ST_WAIT_SCAN;
                end
                ST_WAIT_SCAN: begin
                    if (wait_done) begin
                        wait_cnt_reg <= j_reg;
                        idx_reg      <= '0;
                        state_reg    <= ST_REQ_SCAN;
                    end else if (step) begin
                        idx_reg <= idx_inc;
                        if (wait_we) begin
                            j_reg <= j_reg + 1'b1;
                        end
                    end
                end
                ST_SEND_WAIT: begin
                    if (step) begin
                        if (!wait_full) begin
                            wait_cnt_reg <= wait_cnt_reg + 1'b1;
                        end
                        idx_reg        <= '0;
                        hit_found_reg  <= 1'b0;
                        free_found_reg <= 1'b0;
                        state_reg      <= ST_REQ_SCAN;
                    end
                end
                ST_REQ_SCAN: begin
                    if (step) begin
                        idx_reg <= req_last ? '0 : idx_inc;
                        if (item_reg.operation == OP_SEND) begin
                            if (req_ip_hit) begin
                                hit_found_reg <= 1'b1;
                            end
                            if (!req_v && !free_found_reg) begin
                                free_found_reg <= 1'b1;
                                free_idx_reg   <= idx_reg;
                            end
                        end else if (item_reg.operation == OP_RECV) begin
                            if (req_ip_hit && !hit_found_reg) begin
                                hit_found_reg                   <= 1'b1;
                                req_valid_reg[idx_reg[RAW-1:0]] <= 1'b0;
                            end
                        end
                        if (req_last) begin
                            state_reg <= (item_reg.operation == OP_SEND) ? ST_SEND_REQ
                                                                         : ST_FINISH;
                        end
                    end
                end
                ST_SEND_REQ: begin
                    if (step) begin
                        if (req_we) begin
                            req_valid_reg[free_idx_reg[RAW-1:0]] <= 1'b1;
                        end
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH: begin
                    if (!pend_valid_reg || ob_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (emit_req && can_emit) begin
                pend_valid_reg <= 1'b1;
            end else if (state_reg == ST_FINISH && ob_ready) begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit_req && can_emit) begin
            pend_reg <= emit_res;
        end
    end

    a_wait_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        wait_cnt_reg <= WCW'(WAIT_ENTRIES))
        else $error("waiting queue count exceeds its depth");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("result still held while a new transaction is accepted");

    a_last_only_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (ob_valid && state_reg != ST_FINISH) |-> !ob_data.last)
        else $error("last flag set before the transaction finished");

    a_compact_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WAIT_SCAN) |-> (CW'(j_reg) <= idx_reg))
        else $error("waiting queue write index overtook the read index");

endmodule

// ===== sv/arp_resolution_engine_top.sv =====
// Top level of the ARP resolution engine: configuration registers, engine and output register.
//
//   port group   direction  handshake              payload
//   s_*          in         s_valid / s_ready      arpre_in_t  (send, receive, tick)
//   m_*          out        m_valid / m_ready      arpre_out_t (frames, requests, replies, delivers, drops)
//   cfg_*        in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// A send scans the mapping and request memories entry by entry, an ARP receive also
// walks the queued tags between them, and a tick scans the mapping and request memories.
// Reset is synchronous, clears valid bits, counts and the clock, and loads the configuration defaults.
// A stalled result channel holds the scan in place until the result is taken.
module arp_resolution_engine_top import arpre_pkg::*; #(
    parameter int MAP_ENTRIES  = 16,
    parameter int REQ_ENTRIES  = 8,
    parameter int WAIT_ENTRIES = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  arpre_in_t   s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output arpre_out_t  m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [47:0] cfg_data
);

    arpre_cfg_t cfg_reg;
    logic       ob_valid, ob_ready;
    arpre_out_t ob_data;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.own_mac           <= '0;
            cfg_reg.own_ip            <= '0;
            cfg_reg.entry_lifetime_ms <= LIFETIME_RESET;
            cfg_reg.retry_interval_ms <= RETRY_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_OWN_MAC:  cfg_reg.own_mac           <= cfg_data;
                CFG_OWN_IP:   cfg_reg.own_ip            <= cfg_data[31:0];
                CFG_LIFETIME: cfg_reg.entry_lifetime_ms <= cfg_data[19:0];
                CFG_RETRY:    cfg_reg.retry_interval_ms <= cfg_data[19:0];
            endcase
        end
    end

    arpre_core #(
        .MAP_ENTRIES (MAP_ENTRIES),
        .REQ_ENTRIES (REQ_ENTRIES),
        .WAIT_ENTRIES(WAIT_ENTRIES)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .ob_valid(ob_valid),
        .ob_ready(ob_ready),
        .ob_data (ob_data)
    );

    arpre_obuf u_obuf (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(ob_valid),
        .in_ready(ob_ready),
        .in_data (ob_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
